// File: rtl/deq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deq_pkg
// Shared types and constants for the double-ended queue.
// ----------------------------------------------------------------------------
package deq_pkg;

   localparam int DEPTH_DEFAULT      = 1024;
   localparam int DATA_WIDTH_DEFAULT = 32;

   localparam int MODE_W  = 3;
   localparam int VALUE_W = 32;
   localparam int COUNT_W = 11;
   localparam int INDEX_W = 10;
   localparam int ERR_W   = 2;

   typedef enum logic [MODE_W-1:0] {
      MODE_PUSH_FRONT = 3'd0,
      MODE_POP_FRONT  = 3'd1,
      MODE_PUSH_BACK  = 3'd2,
      MODE_POP_BACK   = 3'd3,
      MODE_READ       = 3'd4,
      MODE_RESIZE     = 3'd5,
      MODE_CLEAR      = 3'd6,
      MODE_REFILL     = 3'd7
   } mode_type;

   typedef enum logic [ERR_W-1:0] {
      ERR_OK        = 2'd0,
      ERR_UNDERFLOW = 2'd1,
      ERR_OVERFLOW  = 2'd2,
      ERR_RANGE     = 2'd3
   } err_type;

   typedef enum logic [5:0] {
      ST_IDLE     = 6'b000001,
      ST_FILL     = 6'b000010,
      ST_RD_FRONT = 6'b000100,
      ST_RD_BACK  = 6'b001000,
      ST_RD_INDEX = 6'b010000,
      ST_DONE     = 6'b100000
   } state_type;

endpackage

// File: rtl/double_ended_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// double_ended_queue
// Fixed-depth deque in a circular single-port-write store.
// ----------------------------------------------------------------------------
// Usage:
//   A request (req_mode, req_value, req_count, req_index) is taken at a clock
//   edge with start high and busy low. Each request yields one response on
//   the rsp_ ports, shown for exactly one cycle with rsp_valid high: front,
//   back and indexed entries, occupancy, empty flag and error code.
//   The response cannot be held off by the receiver.
// Sequencing:
//   Push/pop/clear bookkeeping is done at the accepting edge. Resize and
//   refill then write each added entry in ST_FILL (one store write per
//   cycle), followed by ST_RD_FRONT, ST_RD_BACK and ST_RD_INDEX, which read
//   front, back and indexed entries through the single store read port, and
//   ST_DONE, which registers the response. busy is low again in the cycle
//   rsp_valid is high, so the next request can be taken at the edge ending
//   that cycle.
// Reset:
//   Synchronous, active high. The queue comes out empty with its head at
//   slot zero; store contents are not cleared, and unwritten ones never reach the rsp_ ports.
// ----------------------------------------------------------------------------
module double_ended_queue #(
   parameter int DEPTH      = deq_pkg::DEPTH_DEFAULT,
   parameter int DATA_WIDTH = deq_pkg::DATA_WIDTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [deq_pkg::MODE_W-1:0]          req_mode,
   input  logic signed [deq_pkg::VALUE_W-1:0]  req_value,
   input  logic [deq_pkg::COUNT_W-1:0]         req_count,
   input  logic [deq_pkg::INDEX_W-1:0]         req_index,
   output logic                                rsp_valid,
   output logic signed [deq_pkg::VALUE_W-1:0]  rsp_front_value,
   output logic signed [deq_pkg::VALUE_W-1:0]  rsp_back_value,
   output logic signed [deq_pkg::VALUE_W-1:0]  rsp_read_value,
   output logic [deq_pkg::COUNT_W-1:0]         rsp_occupancy,
   output logic                                rsp_is_empty,
   output logic [deq_pkg::ERR_W-1:0]           rsp_error_code
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam int XW = (CW > deq_pkg::COUNT_W) ? CW : deq_pkg::COUNT_W;

   // head + offset modulo DEPTH, head below DEPTH and offset at most DEPTH
   function automatic logic [AW-1:0] slot(input logic [AW-1:0] head,
                                          input logic [CW-1:0] off);
      logic [CW:0] sum;
      sum = (CW + 1)'(head) + (CW + 1)'(off);
      if (sum >= (CW + 1)'(DEPTH))
         sum = sum - (CW + 1)'(DEPTH);
      return sum[AW-1:0];
   endfunction

   function automatic logic [deq_pkg::VALUE_W-1:0] to_out(input logic [DATA_WIDTH-1:0] d);
      logic [63:0] w;
      w = 64'(d);
      return w[deq_pkg::VALUE_W-1:0];
   endfunction

   logic [DATA_WIDTH-1:0] store_ff [DEPTH];
   logic [DATA_WIDTH-1:0] rd_data_ff;

   deq_pkg::state_type state_ff, state_in;
   logic [AW-1:0]         head_ff, head_in;
   logic [CW-1:0]         count_ff, count_in;
   logic [CW-1:0]         target_ff, target_in;
   logic [DATA_WIDTH-1:0] val_ff, val_in;
   logic [deq_pkg::INDEX_W-1:0] index_ff, index_in;
   logic                  rd_req_ff, rd_req_in;
   deq_pkg::err_type      err_ff, err_in;
   logic [DATA_WIDTH-1:0] front_ff, front_in;
   logic [DATA_WIDTH-1:0] back_ff, back_in;

   logic                          valid_ff, valid_in;
   logic [deq_pkg::VALUE_W-1:0]   out_front_ff, out_front_in;
   logic [deq_pkg::VALUE_W-1:0]   out_back_ff, out_back_in;
   logic [deq_pkg::VALUE_W-1:0]   out_read_ff, out_read_in;
   logic [deq_pkg::COUNT_W-1:0]   out_occ_ff, out_occ_in;
   logic                          out_empty_ff, out_empty_in;
   logic [deq_pkg::ERR_W-1:0]     out_err_ff, out_err_in;

   logic                  mem_we;
   logic [AW-1:0]         mem_wa;
   logic [DATA_WIDTH-1:0] mem_wd;
   logic [AW-1:0]         mem_ra;

   logic                  accept;
   logic [DATA_WIDTH-1:0] req_val;
   logic [63:0]           req_val64;
   logic [XW-1:0]         req_cnt_x;
   logic [XW-1:0]         req_idx_x;
   logic [XW-1:0]         count_x;
   logic                  full;
   logic                  empty;
   logic [AW-1:0]         head_dec;

   always_comb begin
      accept    = start && (state_ff == deq_pkg::ST_IDLE);
      req_val64 = {32'd0, req_value};
      req_val   = DATA_WIDTH'(req_val64);
      req_cnt_x = XW'(req_count);
      req_idx_x = XW'(req_index);
      count_x   = XW'(count_ff);
      full      = (count_ff == CW'(DEPTH));
      empty     = (count_ff == '0);
      head_dec  = (head_ff == '0) ? AW'(DEPTH - 1) : head_ff - AW'(1);
   end

   always_comb begin
      state_in     = state_ff;
      head_in      = head_ff;
      count_in     = count_ff;
      target_in    = target_ff;
      val_in       = val_ff;
      index_in     = index_ff;
      rd_req_in    = rd_req_ff;
      err_in       = err_ff;
      front_in     = front_ff;
      back_in      = back_ff;
      valid_in     = 1'b0;
      out_front_in = out_front_ff;
      out_back_in  = out_back_ff;
      out_read_in  = out_read_ff;
      out_occ_in   = out_occ_ff;
      out_empty_in = out_empty_ff;
      out_err_in   = out_err_ff;
      mem_we       = 1'b0;
      mem_wa       = slot(head_ff, count_ff);
      mem_wd       = val_ff;
      mem_ra       = head_ff;

      case (state_ff)
         deq_pkg::ST_IDLE: begin
            if (accept) begin
               val_in    = req_val;
               index_in  = req_index;
               rd_req_in = 1'b0;
               err_in    = deq_pkg::ERR_OK;
               state_in  = deq_pkg::ST_RD_FRONT;
               case (deq_pkg::mode_type'(req_mode))
                  deq_pkg::MODE_PUSH_FRONT: begin
                     if (full) begin
                        err_in = deq_pkg::ERR_OVERFLOW;
                     end else begin
                        head_in  = head_dec;
                        count_in = count_ff + CW'(1);
                        mem_we   = 1'b1;
                        mem_wa   = head_dec;
                        mem_wd   = req_val;
                     end
                  end
                  deq_pkg::MODE_POP_FRONT: begin
                     if (empty) begin
                        err_in = deq_pkg::ERR_UNDERFLOW;
                     end else begin
                        head_in  = slot(head_ff, CW'(1));
                        count_in = count_ff - CW'(1);
                     end
                  end
                  deq_pkg::MODE_PUSH_BACK: begin
                     if (full) begin
                        err_in = deq_pkg::ERR_OVERFLOW;
                     end else begin
                        count_in = count_ff + CW'(1);
                        mem_we   = 1'b1;
                        mem_wd   = req_val;
                     end
                  end
                  deq_pkg::MODE_POP_BACK: begin
                     if (empty) begin
                        err_in = deq_pkg::ERR_UNDERFLOW;
                     end else begin
                        count_in = count_ff - CW'(1);
                     end
                  end
                  deq_pkg::MODE_READ: begin
                     if (req_idx_x >= count_x) begin
                        err_in = deq_pkg::ERR_RANGE;
                     end else begin
                        rd_req_in = 1'b1;
                     end
                  end
                  deq_pkg::MODE_RESIZE: begin
                     if (req_cnt_x > XW'(DEPTH)) begin
                        err_in = deq_pkg::ERR_OVERFLOW;
                     end else if (req_cnt_x > count_x) begin
                        target_in = CW'(req_count);
                        state_in  = deq_pkg::ST_FILL;
                     end else begin
                        count_in = CW'(req_count);
                     end
                  end
                  deq_pkg::MODE_CLEAR: begin
                     count_in = '0;
                  end
                  deq_pkg::MODE_REFILL: begin
                     if (req_cnt_x > XW'(DEPTH)) begin
                        err_in = deq_pkg::ERR_OVERFLOW;
                     end else begin
                        head_in   = '0;
                        count_in  = '0;
                        target_in = CW'(req_count);
                        if (req_count != '0)
                           state_in = deq_pkg::ST_FILL;
                     end
                  end
                  default: begin
                     err_in = deq_pkg::ERR_OK;
                  end
               endcase
            end
         end
         deq_pkg::ST_FILL: begin
            mem_we   = 1'b1;
            count_in = count_ff + CW'(1);
            if (count_ff + CW'(1) == target_ff)
               state_in = deq_pkg::ST_RD_FRONT;
         end
         deq_pkg::ST_RD_FRONT: begin
            mem_ra   = head_ff;
            state_in = deq_pkg::ST_RD_BACK;
         end
         deq_pkg::ST_RD_BACK: begin
            mem_ra   = slot(head_ff, empty ? CW'(0) : count_ff - CW'(1));
            front_in = rd_data_ff;
            state_in = deq_pkg::ST_RD_INDEX;
         end
         deq_pkg::ST_RD_INDEX: begin
            mem_ra   = slot(head_ff, rd_req_ff ? CW'(index_ff) : CW'(0));
            back_in  = rd_data_ff;
            state_in = deq_pkg::ST_DONE;
         end
         deq_pkg::ST_DONE: begin
            valid_in     = 1'b1;
            out_front_in = empty ? '0 : to_out(front_ff);
            out_back_in  = empty ? '0 : to_out(back_ff);
            out_read_in  = rd_req_ff ? to_out(rd_data_ff) : '0;
            out_occ_in   = deq_pkg::COUNT_W'(count_ff);
            out_empty_in = empty;
            out_err_in   = err_ff;
            state_in     = deq_pkg::ST_IDLE;
         end
         default: begin
            state_in = deq_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we)
         store_ff[mem_wa] <= mem_wd;
      rd_data_ff <= store_ff[mem_ra];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= deq_pkg::ST_IDLE;
         head_ff  <= '0;
         count_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
         count_ff <= count_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      target_ff    <= target_in;
      val_ff       <= val_in;
      index_ff     <= index_in;
      rd_req_ff    <= rd_req_in;
      err_ff       <= err_in;
      front_ff     <= front_in;
      back_ff      <= back_in;
      out_front_ff <= out_front_in;
      out_back_ff  <= out_back_in;
      out_read_ff  <= out_read_in;
      out_occ_ff   <= out_occ_in;
      out_empty_ff <= out_empty_in;
      out_err_ff   <= out_err_in;
   end

   assign busy            = (state_ff != deq_pkg::ST_IDLE);
   assign rsp_valid       = valid_ff;
   assign rsp_front_value = out_front_ff;
   assign rsp_back_value  = out_back_ff;
   assign rsp_read_value  = out_read_ff;
   assign rsp_occupancy   = out_occ_ff;
   assign rsp_is_empty    = out_empty_ff;
   assign rsp_error_code  = out_err_ff;

endmodule

// File: tb/sv/double_ended_queue_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// double_ended_queue_test
// Self-checking bench for the double-ended queue. A short directed opening
// hits empty, full and out-of-range cases; a long random run follows with
// random gaps between requests. Every response is compared field by field
// with a shadow copy of the circular store, head and entry count.
// ----------------------------------------------------------------------------
module double_ended_queue_test;

   localparam int DEPTH           = deq_pkg::DEPTH_DEFAULT;
   localparam int RANDOM_REQUESTS = 1600;
   localparam int IDLE_LIMIT      = 10000;
   localparam int TAIL_CYCLES     = 16;
   localparam int PRINT_LIMIT     = 100;

   typedef struct {
      deq_pkg::mode_type           mode;
      logic [deq_pkg::VALUE_W-1:0] value;
      logic [deq_pkg::COUNT_W-1:0] count;
      logic [deq_pkg::INDEX_W-1:0] index;
      bit                          drain;
   } deque_request_type;

   typedef struct {
      logic [deq_pkg::VALUE_W-1:0] front_value;
      logic [deq_pkg::VALUE_W-1:0] back_value;
      logic [deq_pkg::VALUE_W-1:0] read_value;
      logic [deq_pkg::COUNT_W-1:0] occupancy;
      logic                        is_empty;
      deq_pkg::err_type            error_code;
   } deque_status_type;

   logic                                clock     = 1'b0;
   logic                                reset     = 1'b1;
   logic                                start     = 1'b0;
   logic [deq_pkg::MODE_W-1:0]          req_mode  = '0;
   logic signed [deq_pkg::VALUE_W-1:0]  req_value = '0;
   logic [deq_pkg::COUNT_W-1:0]         req_count = '0;
   logic [deq_pkg::INDEX_W-1:0]         req_index = '0;
   logic                                busy;
   logic                                rsp_valid;
   logic signed [deq_pkg::VALUE_W-1:0]  rsp_front_value;
   logic signed [deq_pkg::VALUE_W-1:0]  rsp_back_value;
   logic signed [deq_pkg::VALUE_W-1:0]  rsp_read_value;
   logic [deq_pkg::COUNT_W-1:0]         rsp_occupancy;
   logic                                rsp_is_empty;
   logic [deq_pkg::ERR_W-1:0]           rsp_error_code;

   double_ended_queue dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_mode        (req_mode),
      .req_value       (req_value),
      .req_count       (req_count),
      .req_index       (req_index),
      .rsp_valid       (rsp_valid),
      .rsp_front_value (rsp_front_value),
      .rsp_back_value  (rsp_back_value),
      .rsp_read_value  (rsp_read_value),
      .rsp_occupancy   (rsp_occupancy),
      .rsp_is_empty    (rsp_is_empty),
      .rsp_error_code  (rsp_error_code)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // shadow of the deque
   logic [deq_pkg::VALUE_W-1:0] shadow_words [DEPTH];
   logic [deq_pkg::INDEX_W-1:0] shadow_head = '0;
   int unsigned                 shadow_size = 0;

   deque_request_type request_backlog [$];
   deque_status_type  awaited_status [$];
   deque_request_type driven_request;

   int unsigned gap_left       = 0;
   int unsigned calm_left      = 0;
   int unsigned idle_cycles    = 0;
   int unsigned requests_taken = 0;
   int unsigned responses_seen = 0;
   int unsigned mismatch_count = 0;
   int unsigned peak_occupancy = 0;
   int unsigned error_hits [4] = '{0, 0, 0, 0};

   function automatic logic [deq_pkg::INDEX_W-1:0] slot_of(int unsigned offset);
      return shadow_head + deq_pkg::INDEX_W'(offset);
   endfunction

   function automatic deque_status_type apply_request(deque_request_type r);
      deque_status_type s;
      int unsigned      k;
      s.read_value = '0;
      s.error_code = deq_pkg::ERR_OK;
      case (r.mode)
         deq_pkg::MODE_PUSH_FRONT: begin
            if (shadow_size >= DEPTH) begin
               s.error_code = deq_pkg::ERR_OVERFLOW;
            end else begin
               shadow_head = shadow_head - 1'b1;
               shadow_words[shadow_head] = r.value;
               shadow_size++;
            end
         end
         deq_pkg::MODE_POP_FRONT: begin
            if (shadow_size == 0) begin
               s.error_code = deq_pkg::ERR_UNDERFLOW;
            end else begin
               shadow_head = shadow_head + 1'b1;
               shadow_size--;
            end
         end
         deq_pkg::MODE_PUSH_BACK: begin
            if (shadow_size >= DEPTH) begin
               s.error_code = deq_pkg::ERR_OVERFLOW;
            end else begin
               shadow_words[slot_of(shadow_size)] = r.value;
               shadow_size++;
            end
         end
         deq_pkg::MODE_POP_BACK: begin
            if (shadow_size == 0) s.error_code = deq_pkg::ERR_UNDERFLOW;
            else shadow_size--;
         end
         deq_pkg::MODE_READ: begin
            if (r.index >= shadow_size) s.error_code = deq_pkg::ERR_RANGE;
            else s.read_value = shadow_words[slot_of(r.index)];
         end
         deq_pkg::MODE_RESIZE: begin
            if (r.count > DEPTH) begin
               s.error_code = deq_pkg::ERR_OVERFLOW;
            end else begin
               while (shadow_size < r.count) begin
                  shadow_words[slot_of(shadow_size)] = r.value;
                  shadow_size++;
               end
               shadow_size = r.count;
            end
         end
         deq_pkg::MODE_CLEAR: begin
            shadow_size = 0;
         end
         deq_pkg::MODE_REFILL: begin
            if (r.count > DEPTH) begin
               s.error_code = deq_pkg::ERR_OVERFLOW;
            end else begin
               shadow_head = '0;
               for (k = 0; k < r.count; k++)
                  shadow_words[deq_pkg::INDEX_W'(k)] = r.value;
               shadow_size = r.count;
            end
         end
         default: begin
         end
      endcase
      if (shadow_size != 0) begin
         s.front_value = shadow_words[slot_of(0)];
         s.back_value  = shadow_words[slot_of(shadow_size - 1)];
      end else begin
         s.front_value = '0;
         s.back_value  = '0;
      end
      s.occupancy = deq_pkg::COUNT_W'(shadow_size);
      s.is_empty  = (shadow_size == 0);
      return s;
   endfunction

   function automatic void queue_request(deq_pkg::mode_type m,
                                         logic [deq_pkg::VALUE_W-1:0] v,
                                         int unsigned c, int unsigned i, bit d = 1'b0);
      deque_request_type r;
      r.mode  = m;
      r.value = v;
      r.count = deq_pkg::COUNT_W'(c);
      r.index = deq_pkg::INDEX_W'(i);
      r.drain = d;
      request_backlog.insert(request_backlog.size(), r);
   endfunction

   function automatic deque_request_type random_request();
      deque_request_type r;
      int unsigned       pick;
      int unsigned       size_now;
      size_now = shadow_size;
      r.value  = $urandom();
      r.count  = deq_pkg::COUNT_W'($urandom());
      r.index  = deq_pkg::INDEX_W'($urandom());
      r.drain  = 1'b0;
      if ($urandom_range(0, 99) < 5) begin
         case ($urandom_range(0, 3))
            0: r.value = '0;
            1: r.value = 32'h8000_0000;
            2: r.value = 32'h7fff_ffff;
            default: r.value = '1;
         endcase
      end
      pick = $urandom_range(0, 99);
      if (pick < 18) r.mode = deq_pkg::MODE_PUSH_FRONT;
      else if (pick < 36) r.mode = deq_pkg::MODE_PUSH_BACK;
      else if (pick < 48) r.mode = deq_pkg::MODE_POP_FRONT;
      else if (pick < 60) r.mode = deq_pkg::MODE_POP_BACK;
      else if (pick < 84) r.mode = deq_pkg::MODE_READ;
      else if (pick < 91) r.mode = deq_pkg::MODE_RESIZE;
      else if (pick < 93) r.mode = deq_pkg::MODE_CLEAR;
      else r.mode = deq_pkg::MODE_REFILL;
      pick = $urandom_range(0, 99);
      if (r.mode == deq_pkg::MODE_READ) begin
         if (pick < 80 && size_now > 0)
            r.index = deq_pkg::INDEX_W'($urandom_range(0, size_now - 1));
         else if (pick < 90) r.index = deq_pkg::INDEX_W'(size_now);
      end else if (r.mode == deq_pkg::MODE_RESIZE || r.mode == deq_pkg::MODE_REFILL) begin
         if (pick < 70) r.count = deq_pkg::COUNT_W'($urandom_range(0, 40));
         else if (pick < 85)
            r.count = deq_pkg::COUNT_W'($urandom_range(0,
                         (size_now + 8 > DEPTH) ? DEPTH : size_now + 8));
         else if (pick < 92) r.count = deq_pkg::COUNT_W'($urandom_range(1000, DEPTH));
         else r.count = deq_pkg::COUNT_W'($urandom_range(DEPTH + 1, 2047));
      end
      return r;
   endfunction

   // mostly back-to-back, some short gaps, a few long ones, and calm stretches
   function automatic int unsigned pick_gap();
      int unsigned pick;
      if (calm_left != 0) begin
         calm_left--;
         return 0;
      end
      pick = $urandom_range(0, 99);
      if (pick < 2) calm_left = $urandom_range(20, 80);
      if (pick < 60) return 0;
      if (pick < 92) return $urandom_range(1, 7);
      return $urandom_range(8, 60);
   endfunction

   task automatic report_mismatch(string msg);
      if (mismatch_count < PRINT_LIMIT) $display("mismatch at %0t: %s", $realtime, msg);
      mismatch_count++;
   endtask

   task automatic check_field(string name, logic [deq_pkg::VALUE_W-1:0] got,
                              logic [deq_pkg::VALUE_W-1:0] want);
      if (got !== want)
         report_mismatch($sformatf("response %0d %s: got %h, expected %h",
                                   responses_seen, name, got, want));
   endtask

   // driver
   always @(posedge clock) begin
      deque_status_type predicted;
      bit               holding;
      if (reset) begin
         start <= 1'b0;
      end else begin
         holding = start && busy;
         if (start && !busy) begin
            predicted = apply_request(driven_request);
            awaited_status.insert(awaited_status.size(), predicted);
            error_hits[predicted.error_code]++;
            if (predicted.occupancy > peak_occupancy) peak_occupancy = predicted.occupancy;
            requests_taken++;
            gap_left = pick_gap();
         end
         if (!holding) begin
            if (gap_left == 0 && request_backlog.size() != 0 &&
                !(request_backlog[0].drain && awaited_status.size() != 0)) begin
               driven_request = request_backlog[0];
               request_backlog.delete(0);
               start     <= 1'b1;
               req_mode  <= driven_request.mode;
               req_value <= driven_request.value;
               req_count <= driven_request.count;
               req_index <= driven_request.index;
            end else begin
               if (gap_left != 0) gap_left--;
               start     <= 1'b0;
               req_mode  <= deq_pkg::MODE_W'($urandom());
               req_value <= $urandom();
               req_count <= deq_pkg::COUNT_W'($urandom());
               req_index <= deq_pkg::INDEX_W'($urandom());
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      deque_status_type want;
      if (!reset && rsp_valid) begin
         responses_seen++;
         if (awaited_status.size() == 0) begin
            report_mismatch($sformatf("response %0d with no request outstanding",
                                      responses_seen));
         end else begin
            want = awaited_status[0];
            awaited_status.delete(0);
            check_field("front_value", rsp_front_value, want.front_value);
            check_field("back_value", rsp_back_value, want.back_value);
            check_field("read_value", rsp_read_value, want.read_value);
            check_field("occupancy", deq_pkg::VALUE_W'(rsp_occupancy),
                        deq_pkg::VALUE_W'(want.occupancy));
            check_field("is_empty", deq_pkg::VALUE_W'(rsp_is_empty),
                        deq_pkg::VALUE_W'(want.is_empty));
            check_field("error_code", deq_pkg::VALUE_W'(rsp_error_code),
                        deq_pkg::VALUE_W'(want.error_code));
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout: no request or response for %0d cycles", IDLE_LIMIT);
            $display("double_ended_queue_test: FAIL");
            $finish;
         end
      end
   end

   initial begin
      deque_request_type req;
      int unsigned       n;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      queue_request(deq_pkg::MODE_POP_FRONT, '0, 0, 0);
      queue_request(deq_pkg::MODE_POP_BACK, '0, 0, 0);
      queue_request(deq_pkg::MODE_READ, '0, 0, 0);
      queue_request(deq_pkg::MODE_PUSH_FRONT, 32'h8000_0000, 0, 0);
      queue_request(deq_pkg::MODE_PUSH_BACK, 32'h7fff_ffff, 0, 0);
      queue_request(deq_pkg::MODE_PUSH_FRONT, 32'hffff_ffff, 0, 0);
      queue_request(deq_pkg::MODE_READ, '0, 0, 0);
      queue_request(deq_pkg::MODE_READ, '0, 0, 2);
      queue_request(deq_pkg::MODE_READ, '0, 0, 3);
      queue_request(deq_pkg::MODE_READ, '0, 0, 1023);
      queue_request(deq_pkg::MODE_POP_FRONT, '0, 0, 0);
      queue_request(deq_pkg::MODE_POP_BACK, '0, 0, 0);
      queue_request(deq_pkg::MODE_RESIZE, 32'h1111_1111, DEPTH + 1, 0);
      queue_request(deq_pkg::MODE_REFILL, 32'h2222_2222, 2047, 0);
      queue_request(deq_pkg::MODE_RESIZE, 32'h5a5a_5a5a, 6, 0);
      queue_request(deq_pkg::MODE_RESIZE, 32'h3333_3333, 2, 0);
      queue_request(deq_pkg::MODE_CLEAR, '0, 0, 0, 1'b1);
      queue_request(deq_pkg::MODE_PUSH_BACK, 32'h0000_0001, 0, 0);
      queue_request(deq_pkg::MODE_REFILL, 32'ha5a5_a5a5, DEPTH, 0);
      queue_request(deq_pkg::MODE_PUSH_FRONT, 32'h4444_4444, 0, 0);
      queue_request(deq_pkg::MODE_PUSH_BACK, 32'h5555_5555, 0, 0);
      queue_request(deq_pkg::MODE_READ, '0, 0, 1023);
      queue_request(deq_pkg::MODE_RESIZE, 32'h6666_6666, DEPTH, 0);
      queue_request(deq_pkg::MODE_RESIZE, 32'h7777_7777, 0, 0);
      queue_request(deq_pkg::MODE_REFILL, 32'h1234_5678, 0, 0);

      for (n = 0; n < RANDOM_REQUESTS; n++) begin
         while (request_backlog.size() >= 2) @(negedge clock);
         req = random_request();
         req.drain = (n % 400 == 399);
         request_backlog.insert(request_backlog.size(), req);
      end

      while (request_backlog.size() != 0 || start) @(negedge clock);
      while (awaited_status.size() != 0) @(negedge clock);
      repeat (TAIL_CYCLES) @(negedge clock);

      $display("summary: %0d requests, %0d responses checked, peak occupancy %0d",
               requests_taken, responses_seen, peak_occupancy);
      $display("summary: ok %0d, underflow %0d, overflow %0d, out of range %0d",
               error_hits[deq_pkg::ERR_OK], error_hits[deq_pkg::ERR_UNDERFLOW],
               error_hits[deq_pkg::ERR_OVERFLOW], error_hits[deq_pkg::ERR_RANGE]);
      if (mismatch_count == 0) begin
         $display("double_ended_queue_test: PASS");
      end else begin
         $display("double_ended_queue_test: FAIL");
      end
      $finish;
   end

endmodule
